// ----- hdl/spc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_pkg
// Shared constants and controller/datapath interface types for the shaded
// palette colour-map core.
// ----------------------------------------------------------------------------
package spc_pkg;

  // Field widths fixed by the interface.
  localparam int IDX_W   = 8;
  localparam int CHAN_W  = 8;
  localparam int SHADE_W = 6;
  localparam int FB_W    = 9;
  localparam int ENTRY_W = 3 * CHAN_W;

  // Default sizes of the palette and the light levels.
  localparam int PALETTE_SIZE_DEF = 256;
  localparam int SHADE_LEVELS_DEF = 64;

  // A shade of 32 leaves a channel unchanged, so the product is shifted by 5.
  localparam int UNIT_SHADE_SHIFT = 5;
  localparam logic [CHAN_W-1:0] CHANNEL_MAX = 8'd255;
  localparam logic [FB_W-1:0]   FULLBRIGHT_RESET = 9'd24;

  // Distance is the sum of three squared 8-bit differences.
  localparam int SQ_W   = 2 * CHAN_W;
  localparam int DIST_W = SQ_W + 2;

  // Action codes of an input transfer.
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr_en;      // write one palette entry
    logic src_rd;     // read the colour to be shaded, capture the level
    logic emit_self;  // fullbright: return the colour's own index
    logic shade_load; // shade the source colour and clear the search
    logic scan_rd;    // read the next palette entry of the search
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fullbright; // the offered colour is a fullbright
    logic cnt_last;   // the scan counter is on the final entry
    logic done;       // the final entry is being compared
  } status_t;

endpackage

// ----- hdl/spc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_ctrl
// Controller of the colour-map core: takes input transfers and sequences the
// source read, the shading step and the palette scan.
// ----------------------------------------------------------------------------
module spc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             in_action,
  input  spc_pkg::status_t status,
  output spc_pkg::cmd_t    cmd,
  output logic             busy
);
  import spc_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SRC  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_WAIT = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       accept;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // Commands follow the state and the offered transfer.
  always_comb begin
    cmd            = '0;
    cmd.wr_en      = accept && (in_action == ACT_LOAD);
    cmd.emit_self  = accept && (in_action == ACT_LOOKUP) && status.fullbright;
    cmd.src_rd     = accept && (in_action == ACT_LOOKUP) && !status.fullbright;
    cmd.shade_load = (state_r == S_SRC);
    cmd.scan_rd    = (state_r == S_SCAN);
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.src_rd) begin
          state_nxt = S_SRC;
        end
      end
      S_SRC: begin
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (status.cnt_last) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (status.done) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- hdl/spc_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_dpath
// Datapath of the colour-map core: palette memory, fullbright register,
// channel shading and a three-stage distance search over the palette.
// ----------------------------------------------------------------------------
module spc_dpath #(
  parameter int PALETTE_SIZE = spc_pkg::PALETTE_SIZE_DEF,
  parameter int SHADE_LEVELS = spc_pkg::SHADE_LEVELS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  spc_pkg::cmd_t               cmd,
  output spc_pkg::status_t            status,
  input  logic [spc_pkg::IDX_W-1:0]   in_colour_index,
  input  logic [spc_pkg::CHAN_W-1:0]  in_red,
  input  logic [spc_pkg::CHAN_W-1:0]  in_green,
  input  logic [spc_pkg::CHAN_W-1:0]  in_blue,
  input  logic [spc_pkg::SHADE_W-1:0] in_shade_level,
  input  logic                        cfg_we,
  input  logic [spc_pkg::FB_W-1:0]    cfg_data,
  output logic                        out_valid,
  output logic [spc_pkg::IDX_W-1:0]   out_nearest_index
);
  import spc_pkg::*;

  localparam int AW    = $clog2(PALETTE_SIZE);
  localparam int LVL_W = $clog2(SHADE_LEVELS);
  localparam int SUM_W = IDX_W + 2;
  localparam int PROD_W = CHAN_W + SHADE_W;

  // Palette memory and its registered read port.
  logic [ENTRY_W-1:0] mem [PALETTE_SIZE];
  logic [ENTRY_W-1:0] rdata_r;
  logic [AW-1:0]      raddr;
  logic               in_range;

  // Configuration and captured lookup state.
  logic [FB_W-1:0]    fb_r;
  logic [LVL_W-1:0]   lvl_r;
  logic [SHADE_W-1:0] lvl_sat;

  // Shaded target colour.
  logic [CHAN_W-1:0] tgt_r_r, tgt_g_r, tgt_b_r;
  logic [CHAN_W-1:0] shd_r, shd_g, shd_b;

  // Scan pipeline.
  logic [AW-1:0]     cnt_r;
  logic              rd_valid_r, rd_last_r;
  logic [AW-1:0]     rd_idx_r;
  logic              sq_valid_r, sq_last_r;
  logic [AW-1:0]     sq_idx_r;
  logic [SQ_W-1:0]   sq_r_r, sq_g_r, sq_b_r;
  logic [DIST_W-1:0] sum_sq;
  logic [DIST_W-1:0] min_sq_r;
  logic [AW-1:0]     best_idx_r;
  logic              better;

  logic              out_valid_r;
  logic [IDX_W-1:0]  out_index_r;

  // Shades one channel: multiply by the level, drop five bits, clamp to 255.
  function automatic logic [CHAN_W-1:0] shade_chan(input logic [CHAN_W-1:0]  c,
                                                   input logic [SHADE_W-1:0] lvl);
    logic [PROD_W-1:0] prod;
    prod = c * lvl;
    if (prod[PROD_W-1:UNIT_SHADE_SHIFT] > {1'b0, CHANNEL_MAX}) begin
      shade_chan = CHANNEL_MAX;
    end else begin
      shade_chan = prod[UNIT_SHADE_SHIFT +: CHAN_W];
    end
  endfunction

  // Absolute difference squared.
  function automatic logic [SQ_W-1:0] sq_diff(input logic [CHAN_W-1:0] a,
                                              input logic [CHAN_W-1:0] b);
    logic [CHAN_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    sq_diff = d * d;
  endfunction

  // A colour is a fullbright when index plus count reaches the palette size.
  assign status.fullbright =
    ({2'b00, in_colour_index} + {1'b0, fb_r}) >= SUM_W'(PALETTE_SIZE);
  assign status.cnt_last = (cnt_r == AW'(PALETTE_SIZE - 1));
  assign status.done     = sq_valid_r && sq_last_r;

  assign in_range = {1'b0, in_colour_index} < (IDX_W + 1)'(PALETTE_SIZE);
  assign raddr    = cmd.src_rd ? in_colour_index[AW-1:0] : cnt_r;
  assign lvl_sat  = (in_shade_level > SHADE_W'(SHADE_LEVELS - 1)) ?
                    SHADE_W'(SHADE_LEVELS - 1) : in_shade_level;

  // Palette write on load, read for the source colour or the scan.
  always_ff @(posedge clk) begin
    if (cmd.wr_en && in_range) begin
      mem[in_colour_index[AW-1:0]] <= {in_red, in_green, in_blue};
    end
    if (cmd.src_rd || cmd.scan_rd) begin
      rdata_r <= mem[raddr];
    end
  end

  // Fullbright count register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fb_r <= FULLBRIGHT_RESET;
    end else if (cfg_we) begin
      fb_r <= cfg_data;
    end
  end

  // Capture the saturated light level with the source read.
  always_ff @(posedge clk) begin
    if (cmd.src_rd) begin
      lvl_r <= lvl_sat[LVL_W-1:0];
    end
  end

  // Shading of the source entry.
  always_comb begin
    shd_r = shade_chan(rdata_r[2*CHAN_W +: CHAN_W], SHADE_W'(lvl_r));
    shd_g = shade_chan(rdata_r[CHAN_W +: CHAN_W], SHADE_W'(lvl_r));
    shd_b = shade_chan(rdata_r[0 +: CHAN_W], SHADE_W'(lvl_r));
  end

  always_ff @(posedge clk) begin
    if (cmd.shade_load) begin
      tgt_r_r <= shd_r;
      tgt_g_r <= shd_g;
      tgt_b_r <= shd_b;
    end
  end

  // Scan counter, read stage and square stage control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      rd_valid_r <= 1'b0;
      sq_valid_r <= 1'b0;
    end else begin
      if (cmd.shade_load) begin
        cnt_r <= '0;
      end else if (cmd.scan_rd) begin
        cnt_r <= status.cnt_last ? '0 : cnt_r + 1'b1;
      end
      rd_valid_r <= cmd.scan_rd;
      sq_valid_r <= rd_valid_r;
    end
  end

  // Squared differences of the entry just read.
  always_ff @(posedge clk) begin
    rd_idx_r  <= cnt_r;
    rd_last_r <= status.cnt_last;
    sq_idx_r  <= rd_idx_r;
    sq_last_r <= rd_last_r;
    sq_r_r    <= sq_diff(tgt_r_r, rdata_r[2*CHAN_W +: CHAN_W]);
    sq_g_r    <= sq_diff(tgt_g_r, rdata_r[CHAN_W +: CHAN_W]);
    sq_b_r    <= sq_diff(tgt_b_r, rdata_r[0 +: CHAN_W]);
  end

  // Sum and compare; a strict less-than keeps the lowest index on a tie.
  assign sum_sq = DIST_W'(sq_r_r) + DIST_W'(sq_g_r) + DIST_W'(sq_b_r);
  assign better = sum_sq < min_sq_r;

  always_ff @(posedge clk) begin
    if (cmd.shade_load) begin
      min_sq_r   <= '1;
      best_idx_r <= '0;
    end else if (sq_valid_r && better) begin
      min_sq_r   <= sum_sq;
      best_idx_r <= sq_idx_r;
    end
  end

  // Result register: one-cycle strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit_self || status.done;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_self) begin
      out_index_r <= in_colour_index;
    end else if (status.done) begin
      out_index_r <= IDX_W'(better ? sq_idx_r : best_idx_r);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_nearest_index = out_index_r;

endmodule

// ----- hdl/shaded_palette_colormap_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shaded_palette_colormap_core
// Palette colour map: loads RGB palette entries and maps a shaded colour to
// its nearest palette index.
// ----------------------------------------------------------------------------
// A load transfer writes one palette entry and gives no result. A lookup of a
// fullbright colour returns its own index in the cycle after the transfer and
// keeps busy low. Any other lookup raises busy: the source entry is read at
// the transfer itself, the shading state shades it, then the search reads the
// palette memory's one read port once a cycle, one palette entry at a time,
// and the search pipeline drains. Its result appears in the first cycle with
// busy low.
// Each result is presented on out_nearest_index for exactly one cycle with
// out_valid high; the receiver cannot stall it, and it must take it then.
// The palette must be fully loaded before the first shaded lookup. Write
// cfg_data only while the block is idle.
// ----------------------------------------------------------------------------
module shaded_palette_colormap_core #(
  parameter int PALETTE_SIZE = spc_pkg::PALETTE_SIZE_DEF,
  parameter int SHADE_LEVELS = spc_pkg::SHADE_LEVELS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_action,
  input  logic [spc_pkg::IDX_W-1:0]   in_colour_index,
  input  logic [spc_pkg::CHAN_W-1:0]  in_red,
  input  logic [spc_pkg::CHAN_W-1:0]  in_green,
  input  logic [spc_pkg::CHAN_W-1:0]  in_blue,
  input  logic [spc_pkg::SHADE_W-1:0] in_shade_level,
  output logic                        out_valid,
  output logic [spc_pkg::IDX_W-1:0]   out_nearest_index,
  input  logic                        cfg_we,
  input  logic [spc_pkg::FB_W-1:0]    cfg_data
);
  import spc_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencing of transfers, shading and the scan.
  spc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_action (in_action),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy)
  );

  // Palette storage and the nearest-colour search.
  spc_dpath #(
    .PALETTE_SIZE (PALETTE_SIZE),
    .SHADE_LEVELS (SHADE_LEVELS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_colour_index   (in_colour_index),
    .in_red            (in_red),
    .in_green          (in_green),
    .in_blue           (in_blue),
    .in_shade_level    (in_shade_level),
    .cfg_we            (cfg_we),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_nearest_index (out_nearest_index)
  );

endmodule
